>>> src/xml_text_escaper_top_assert.svh
// assertion macros for the xml text escaper
// used at the end of xml_text_escaper_top; expects clk and rst_n in scope
`ifndef XML_TEXT_ESCAPER_TOP_ASSERT_SVH
`define XML_TEXT_ESCAPER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define XTE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xte check failed");

// next-cycle implication, checked outside reset
`define XTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xte check failed");

`endif

>>> src/xte_pkg.sv
// package for the xml text escaper: sequence descriptor type, codes and
// character helper functions; no dependencies
`timescale 1ns / 1ps

package xte_pkg;

  // output sequence kinds
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_ENT   = 2'd1;
  localparam logic [1:0] KIND_REF   = 2'd2;

  // named entity codes
  localparam logic [2:0] ENT_LT   = 3'd0;
  localparam logic [2:0] ENT_GT   = 3'd1;
  localparam logic [2:0] ENT_AMP  = 3'd2;
  localparam logic [2:0] ENT_QUOT = 3'd3;
  localparam logic [2:0] ENT_APOS = 3'd4;

  localparam int CP_W  = 21;
  localparam int LEN_W = 4;

  // lengths of each output sequence
  localparam logic [LEN_W-1:0] LEN_PLAIN   = 4'd1;
  localparam logic [LEN_W-1:0] LEN_LTGT    = 4'd4;
  localparam logic [LEN_W-1:0] LEN_AMP     = 4'd5;
  localparam logic [LEN_W-1:0] LEN_QUOTE   = 4'd6;
  localparam logic [LEN_W-1:0] LEN_REF4    = 4'd8;
  localparam logic [LEN_W-1:0] LEN_REF6    = 4'd10;
  localparam logic [LEN_W-1:0] REF_PREFIX  = 4'd3;

  // one pending output sequence
  typedef struct packed {
    logic [1:0]       kind;
    logic [2:0]       ent;
    logic [7:0]       ch;
    logic [CP_W-1:0]  cp;
    logic             wide;
    logic [LEN_W-1:0] len;
  } xte_desc_t;

  // lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end
    return 8'h57 + {4'h0, nib};
  endfunction

  // character idx of a named entity, left justified in 48 bits
  function automatic logic [7:0] ent_char(input logic [2:0] ent,
                                          input logic [LEN_W-1:0] idx);
    logic [47:0] str;
    logic [47:0] sh;
    unique case (ent)
      ENT_LT:   str = {"&lt;", 16'h0};
      ENT_GT:   str = {"&gt;", 16'h0};
      ENT_AMP:  str = {"&amp;", 8'h0};
      ENT_QUOT: str = "&quot;";
      ENT_APOS: str = "&apos;";
      default:  str = '0;
    endcase
    sh = str << {idx, 3'b000};
    return sh[47:40];
  endfunction

  // character idx of a numeric reference &#xHHHH; or &#xHHHHHH;
  function automatic logic [7:0] ref_char(input logic [CP_W-1:0] cp,
                                          input logic wide,
                                          input logic [LEN_W-1:0] idx,
                                          input logic [LEN_W-1:0] len);
    logic [23:0]      pre;
    logic [23:0]      sh;
    logic [2:0]       pos;
    logic [2:0]       k;
    logic [CP_W-1:0]  cps;
    pre = "&#x";
    sh  = pre << {idx, 3'b000};
    pos = 3'(idx - REF_PREFIX);
    k   = (wide ? 3'd5 : 3'd3) - pos;
    cps = cp >> {k, 2'b00};
    if (idx < REF_PREFIX) begin
      return sh[23:16];
    end
    if (idx == len - 4'd1) begin
      return 8'h3B;
    end
    return hex_char(cps[3:0]);
  endfunction

endpackage

>>> src/xml_text_escaper_top.sv
// xml text escaper top level: decode, sequence register and output register
// depends on xte_pkg and xml_text_escaper_top_assert.svh
`timescale 1ns / 1ps

// One text byte per input transfer; the escaped text leaves one byte per output
// transfer, out_tlast marking the last byte caused by each input byte. A byte
// yields 1 byte as plain text, 4 to 6 as a named entity, 8 or 10 as a numeric
// reference, none as a UTF-8 lead or non-final or stray continuation byte. The
// next byte is taken when idle or as the held sequence's last byte is loaded.
// Plain text streams at one byte per cycle while out_tready is high, via the
// sequence and output registers. UTF-8 decoding state updates as each byte is
// taken; in_tlast drops any unfinished sequence. cfg_wr_en writes the UTF-8
// reference mode (reset on); use it only while idle, the block does not check.
module xml_text_escaper_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // utf8_references
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] in_byte
  input  logic       in_tlast,      // last_in_string
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_byte
  output logic       out_tlast      // out_last
);

  localparam int CP_W  = xte_pkg::CP_W;
  localparam int LEN_W = xte_pkg::LEN_W;

  logic                utf8_r;
  logic [1:0]          pend_r, pend_nxt;
  logic [CP_W-1:0]     acc_r, acc_nxt;
  logic                busy_r, busy_nxt;
  logic [LEN_W-1:0]    idx_r, idx_nxt;
  xte_pkg::xte_desc_t  desc_r, desc_nxt, dec;
  logic                dec_emit;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_load;
  logic                seq_last;
  logic                in_xfer;
  logic [7:0]          cur_char;
  logic [CP_W-1:0]     acc_shift;

  assign out_load  = !out_valid_r || out_tready;
  assign seq_last  = (idx_r == desc_r.len - 4'd1);
  assign in_tready = !busy_r || (out_load && seq_last);
  assign in_xfer   = in_tvalid && in_tready;
  assign acc_shift = {acc_r[CP_W-7:0], in_tdata[5:0]};

  // decode the incoming byte into a sequence and the next utf-8 state
  always_comb begin
    dec      = '0;
    dec.ch   = in_tdata;
    dec.cp   = acc_shift;
    dec.wide = (acc_shift > 21'h00FFFF);
    dec_emit = 1'b0;
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    if (utf8_r && in_tdata[7]) begin
      priority if (pend_r == 2'd0 && in_tdata[7:4] == 4'hF) begin
        pend_nxt = 2'd3;
        acc_nxt  = {18'h0, in_tdata[2:0]};
      end else if (pend_r == 2'd0 && in_tdata[7:5] == 3'h7) begin
        pend_nxt = 2'd2;
        acc_nxt  = {17'h0, in_tdata[3:0]};
      end else if (pend_r == 2'd0 && in_tdata[7:6] == 2'h3) begin
        pend_nxt = 2'd1;
        acc_nxt  = {16'h0, in_tdata[4:0]};
      end else if (pend_r != 2'd0) begin
        pend_nxt = pend_r - 2'd1;
        acc_nxt  = acc_shift;
        if (pend_r == 2'd1) begin
          dec_emit = 1'b1;
          dec.kind = xte_pkg::KIND_REF;
          dec.len  = dec.wide ? xte_pkg::LEN_REF6 : xte_pkg::LEN_REF4;
        end
      end else begin
        // stray continuation byte yields nothing
        dec_emit = 1'b0;
      end
    end else begin
      dec_emit = 1'b1;
      dec.kind = xte_pkg::KIND_ENT;
      unique case (in_tdata)
        8'h3C: begin dec.ent = xte_pkg::ENT_LT;   dec.len = xte_pkg::LEN_LTGT;  end
        8'h3E: begin dec.ent = xte_pkg::ENT_GT;   dec.len = xte_pkg::LEN_LTGT;  end
        8'h26: begin dec.ent = xte_pkg::ENT_AMP;  dec.len = xte_pkg::LEN_AMP;   end
        8'h22: begin dec.ent = xte_pkg::ENT_QUOT; dec.len = xte_pkg::LEN_QUOTE; end
        8'h27: begin dec.ent = xte_pkg::ENT_APOS; dec.len = xte_pkg::LEN_QUOTE; end
        default: begin
          dec.kind = xte_pkg::KIND_PLAIN;
          dec.len  = xte_pkg::LEN_PLAIN;
        end
      endcase
    end
    if (in_tlast) begin
      pend_nxt = 2'd0;
      acc_nxt  = '0;
    end
  end

  // character at the current position of the held sequence
  always_comb begin
    unique case (desc_r.kind)
      xte_pkg::KIND_PLAIN: cur_char = desc_r.ch;
      xte_pkg::KIND_ENT:   cur_char = xte_pkg::ent_char(desc_r.ent, idx_r);
      xte_pkg::KIND_REF:
        cur_char = xte_pkg::ref_char(desc_r.cp, desc_r.wide, idx_r, desc_r.len);
      default:             cur_char = desc_r.ch;
    endcase
  end

  // sequence register and output register next values
  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    desc_nxt      = desc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        out_data_nxt = cur_char;
        out_last_nxt = seq_last;
        idx_nxt      = idx_r + 4'd1;
        if (seq_last) begin
          busy_nxt = 1'b0;
        end
      end
    end
    if (in_xfer && dec_emit) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      desc_nxt = dec;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf8_r      <= 1'b1;
      pend_r      <= 2'd0;
      acc_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        utf8_r <= cfg_wr_data;
      end
      if (in_xfer) begin
        pend_r <= pend_nxt;
        acc_r  <= acc_nxt;
      end
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    desc_r     <= desc_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
`include "xml_text_escaper_top_assert.svh"

  `XTE_ASSERT_IMPL(a_idx_in_range, busy_r, idx_r < desc_r.len)
  `XTE_ASSERT_NEXT(a_last_clears, in_tvalid && in_tready && in_tlast, pend_r == 2'd0)
  `XTE_ASSERT_NEXT(a_tlast_at_end, busy_r && out_load && seq_last, out_tvalid && out_tlast)
  `XTE_ASSERT_IMPL(a_ready_when_busy, in_tready && busy_r, out_load && seq_last)

endmodule
